@@ rtl/flr_pkg.sv @@
// Shared types and constants for the FASTA line re-wrapper.
`default_nettype none

package flr_pkg;

    // Marker and line-end characters.
    localparam logic [7:0] GT_BYTE = 8'h3E;
    localparam logic [7:0] NL_BYTE = 8'h0A;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Parser modes, one-hot.
    typedef enum logic [3:0] {
        MODE_FIRST  = 4'b0001,
        MODE_HEADER = 4'b0010,
        MODE_SEQ    = 4'b0100,
        MODE_HALT   = 4'b1000
    } flr_mode_t;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } flr_result_t;

    // Results produced by one input item, handed to the result queue.
    typedef struct packed {
        logic [1:0]  count;
        flr_result_t first;
        flr_result_t second;
    } flr_push_t;

endpackage : flr_pkg

`default_nettype wire

@@ rtl/fasta_line_rewrap.sv @@
// Top level of the FASTA line re-wrapper: input register, parser, result queue.
//
// Usage: bytes of a FASTA file enter on the s_ channel, one request per
// byte; s_tlast high marks end of input (s_tdata is then ignored). The
// m_ channel gives the rewrapped bytes; m_tlast marks the last result
// caused by one input request and m_tuser flags a file that did not begin
// with '>' (m_tdata is then zero). The line length is written through
// cfg_wr_en/cfg_wr_data while the block is idle; zero joins the sequence
// into one line.
// A request accepted on s_ is held in the input register, parsed once the
// queue has room, and its results are written to the queue that feeds m_.
// Throughput: one request per cycle while each gives at most one result and
// the receiver takes them; the m_ side moves one result per cycle, so bytes
// that yield two results (a wrap newline or a line closed ahead of a header)
// fill the four-entry result queue and then hold parsing back.
// Reset (aresetn low, synchronous) empties the queue, clears the line
// length and returns the parser to expecting the first '>'.
// When the receiver stalls, results wait in the queue; once it holds more
// than two, parsing pauses and s_tready drops after the input register fills.
`default_nettype none

module fasta_line_rewrap
    import flr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,   // last_of_run
    output logic             m_tuser    // [0] format_error
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    logic       room;
    logic       take;
    flr_push_t  push;

    // The registered request is parsed whenever the queue has room.
    assign take     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || take;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    flr_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (take),
        .item_byte   (in_byte_reg),
        .item_eoi    (in_eoi_reg),
        .item_take   (take),
        .push        (push)
    );

    flr_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule : fasta_line_rewrap

`default_nettype wire

@@ rtl/flr_parse.sv @@
// Parser state and result generation for one registered input byte.
`default_nettype none

module flr_parse
    import flr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        item_valid,
    input  wire logic [7:0]  item_byte,
    input  wire logic        item_eoi,
    input  wire logic        item_take,
    output flr_push_t        push
);

    flr_mode_t   mode_reg, mode_next;
    logic [31:0] fill_reg, fill_next;
    logic        open_reg, open_next;
    logic [31:0] length_reg;
    logic [31:0] fill_inc;
    logic        line_full;

    // Line length register; the user must write it only while idle, the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= '0;
        end else if (cfg_wr_en) begin
            length_reg <= cfg_wr_data;
        end
    end

    // Saturating count of the byte about to be placed on the line.
    assign fill_inc  = (fill_reg == '1) ? fill_reg : fill_reg + 32'd1;
    assign line_full = (fill_inc >= length_reg);

    // Decode the byte against the current mode.
    always_comb begin
        mode_next    = mode_reg;
        fill_next    = fill_reg;
        open_next    = open_reg;
        push         = '0;
        case (mode_reg)
            MODE_FIRST: begin
                push.count = 2'd1;
                if (!item_eoi && item_byte == GT_BYTE) begin
                    push.first = '{data: GT_BYTE, last: 1'b1, err: 1'b0};
                    mode_next  = MODE_HEADER;
                end else begin
                    push.first = '{data: 8'h00, last: 1'b1, err: 1'b1};
                    mode_next  = MODE_HALT;
                end
            end
            MODE_HEADER: begin
                if (item_eoi) begin
                    mode_next = MODE_HALT;
                end else begin
                    push.count = 2'd1;
                    push.first = '{data: item_byte, last: 1'b1, err: 1'b0};
                    if (item_byte == NL_BYTE) begin
                        mode_next = MODE_SEQ;
                        fill_next = '0;
                        open_next = 1'b0;
                    end
                end
            end
            MODE_SEQ: begin
                if (item_eoi) begin
                    if (open_reg) begin
                        push.count = 2'd1;
                        push.first = '{data: NL_BYTE, last: 1'b1, err: 1'b0};
                    end
                    open_next = 1'b0;
                    fill_next = '0;
                    mode_next = MODE_HALT;
                end else if (item_byte == GT_BYTE) begin
                    // Close an open line before the new header.
                    if (open_reg) begin
                        push.count  = 2'd2;
                        push.first  = '{data: NL_BYTE, last: 1'b0, err: 1'b0};
                        push.second = '{data: GT_BYTE, last: 1'b1, err: 1'b0};
                    end else begin
                        push.count = 2'd1;
                        push.first = '{data: GT_BYTE, last: 1'b1, err: 1'b0};
                    end
                    open_next = 1'b0;
                    fill_next = '0;
                    mode_next = MODE_HEADER;
                end else if (item_byte != NL_BYTE) begin
                    if (length_reg != '0 && line_full) begin
                        push.count  = 2'd2;
                        push.first  = '{data: item_byte, last: 1'b0, err: 1'b0};
                        push.second = '{data: NL_BYTE, last: 1'b1, err: 1'b0};
                        fill_next   = '0;
                        open_next   = 1'b0;
                    end else begin
                        push.count = 2'd1;
                        push.first = '{data: item_byte, last: 1'b1, err: 1'b0};
                        open_next  = 1'b1;
                        if (length_reg != '0) begin
                            fill_next = fill_inc;
                        end
                    end
                end
            end
            default: begin
                // Halted: nothing more until reset.
            end
        endcase
        if (!item_valid) begin
            push.count = 2'd0;
        end
    end

    // Parser state advances once per consumed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_FIRST;
            fill_reg <= '0;
            open_reg <= 1'b0;
        end else if (item_take) begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            open_reg <= open_next;
        end
    end

    // A halted parser emits nothing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_HALT |-> push.count == 2'd0)
        else $error("flr_parse: result produced while halted");

    // An error result can only come out of the first-byte check.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0 && push.first.err) |-> mode_reg == MODE_FIRST)
        else $error("flr_parse: error result outside first byte");

    // Once halted, the parser stays halted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_HALT |=> mode_reg == MODE_HALT)
        else $error("flr_parse: left halted mode without reset");

    // With wrapping on, the line never holds more than the length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && mode_reg == MODE_SEQ && length_reg != '0 && !cfg_wr_en
         && fill_reg < length_reg) |=> fill_reg < length_reg)
        else $error("flr_parse: line fill passed line length");

endmodule : flr_parse

`default_nettype wire

@@ rtl/flr_out_fifo.sv @@
// Small result queue taking up to two results per cycle and giving one while the receiver is ready.
`default_nettype none

module flr_out_fifo
    import flr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire flr_push_t  push,
    output logic            room,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // last_of_run
    output logic            m_tuser    // [0] format_error
);

    flr_result_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    pop;
    logic [PTR_W-1:0]        wr_ptr_1;

    assign wr_ptr_1 = wr_ptr_reg + PTR_W'(1);
    assign pop      = m_tvalid && m_tready;
    // Room for the worst case of two results from the next item.
    assign room     = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg].data;
    assign m_tlast  = mem_reg[rd_ptr_reg].last;
    assign m_tuser  = mem_reg[rd_ptr_reg].err;

    assign count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    // Storage writes.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_1] <= push.second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // The fill level never exceeds the storage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("flr_out_fifo: overflow");

    // A push only arrives when there is space for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> room)
        else $error("flr_out_fifo: push without room");

    // Fill level tracks pushes and pops exactly.
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == $past(count_reg) + CNT_W'($past(push.count))
                 - CNT_W'($past(pop)))
        else $error("flr_out_fifo: count mismatch");

endmodule : flr_out_fifo

`default_nettype wire
